// ===== hdl/cfvg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cfvg_pkg;

    localparam int TRIG_ENTRIES = 360;
    localparam int QUARTER_TURN = TRIG_ENTRIES / 4;
    localparam int HALF_TURN    = TRIG_ENTRIES / 2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_XY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_Z         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DIR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE         = 3'd5;

    localparam int DIV_STEPS = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_RAMP_MUL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [6:0] idx;
        logic       neg;
    } t_trig;

    // sine in whole degrees over one quarter turn, scaled by 32768
    function automatic logic [15:0] sine_q(input logic [6:0] idx);
        logic [15:0] v;
        case (idx)
            7'd0: v = 16'd0;         7'd1: v = 16'd572;       7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;      7'd4: v = 16'd2286;      7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;      7'd7: v = 16'd3993;      7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;      7'd10: v = 16'd5690;     7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;     7'd13: v = 16'd7371;     7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;     7'd16: v = 16'd9032;     7'd17: v = 16'd9580;
            7'd18: v = 16'd10126;    7'd19: v = 16'd10668;    7'd20: v = 16'd11207;
            7'd21: v = 16'd11743;    7'd22: v = 16'd12275;    7'd23: v = 16'd12803;
            7'd24: v = 16'd13328;    7'd25: v = 16'd13848;    7'd26: v = 16'd14365;
            7'd27: v = 16'd14876;    7'd28: v = 16'd15384;    7'd29: v = 16'd15886;
            7'd30: v = 16'd16384;    7'd31: v = 16'd16877;    7'd32: v = 16'd17364;
            7'd33: v = 16'd17847;    7'd34: v = 16'd18324;    7'd35: v = 16'd18795;
            7'd36: v = 16'd19261;    7'd37: v = 16'd19720;    7'd38: v = 16'd20174;
            7'd39: v = 16'd20622;    7'd40: v = 16'd21063;    7'd41: v = 16'd21498;
            7'd42: v = 16'd21926;    7'd43: v = 16'd22348;    7'd44: v = 16'd22763;
            7'd45: v = 16'd23170;    7'd46: v = 16'd23571;    7'd47: v = 16'd23965;
            7'd48: v = 16'd24351;    7'd49: v = 16'd24730;    7'd50: v = 16'd25102;
            7'd51: v = 16'd25466;    7'd52: v = 16'd25822;    7'd53: v = 16'd26170;
            7'd54: v = 16'd26510;    7'd55: v = 16'd26842;    7'd56: v = 16'd27166;
            7'd57: v = 16'd27482;    7'd58: v = 16'd27789;    7'd59: v = 16'd28088;
            7'd60: v = 16'd28378;    7'd61: v = 16'd28660;    7'd62: v = 16'd28932;
            7'd63: v = 16'd29197;    7'd64: v = 16'd29452;    7'd65: v = 16'd29698;
            7'd66: v = 16'd29935;    7'd67: v = 16'd30163;    7'd68: v = 16'd30382;
            7'd69: v = 16'd30592;    7'd70: v = 16'd30792;    7'd71: v = 16'd30983;
            7'd72: v = 16'd31164;    7'd73: v = 16'd31336;    7'd74: v = 16'd31499;
            7'd75: v = 16'd31651;    7'd76: v = 16'd31795;    7'd77: v = 16'd31928;
            7'd78: v = 16'd32052;    7'd79: v = 16'd32166;    7'd80: v = 16'd32270;
            7'd81: v = 16'd32365;    7'd82: v = 16'd32449;    7'd83: v = 16'd32524;
            7'd84: v = 16'd32588;    7'd85: v = 16'd32643;    7'd86: v = 16'd32688;
            7'd87: v = 16'd32723;    7'd88: v = 16'd32748;    7'd89: v = 16'd32763;
            7'd90: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // fold an angle (0..359) onto the quarter-turn table
    function automatic t_trig trig_split(input logic [8:0] deg);
        t_trig       t;
        logic [8:0]  r;
        logic [1:0]  q;
        if (deg >= 9'(3 * QUARTER_TURN)) begin
            q = 2'd3;
            r = deg - 9'(3 * QUARTER_TURN);
        end else if (deg >= 9'(HALF_TURN)) begin
            q = 2'd2;
            r = deg - 9'(HALF_TURN);
        end else if (deg >= 9'(QUARTER_TURN)) begin
            q = 2'd1;
            r = deg - 9'(QUARTER_TURN);
        end else begin
            q = 2'd0;
            r = deg;
        end
        t.idx = q[0] ? 7'(9'(QUARTER_TURN) - r) : r[6:0];
        t.neg = q[1];
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/coil_field_vector_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Six-channel coil field generator. Each input word is a tick (tuser = 0) or a
// heading command (tuser = 1, target in tdata). A command clears z and answers
// at once; a tick during a turn steps the heading one degree and rescales
// cos/sin by amp_xy through one shared 15x16 multiplier; any other unpaused
// tick forms amp_z*phase on that multiplier and divides by the period in a
// restoring divider, one quotient bit per cycle, which sets the worst-case
// rate. A paused idle tick only advances the phase and gives no word. Input
// is taken only between items; the output register lets the next item start
// while a word waits.
module coil_field_vector_generator_core
    import cfvg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // [8:0] target_angle
    input  wire logic                 s_axis_tuser,   // [0] cmd
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [15:0] drive_pz, [31:16] drive_nz, [47:32] drive_px, [63:48] drive_nx,
    // [79:64] drive_py, [95:80] drive_ny, [96] rotating
    output logic [103:0]              m_axis_tdata
);

    // config registers
    logic [14:0] r_amp_xy, r_amp_z;
    logic [15:0] r_period;
    logic        r_gradient, r_move_dir, r_pause;

    // block state
    t_state             r_state, n_state;
    logic [8:0]         r_heading, n_heading;
    logic [7:0]         r_steps, n_steps;
    logic               r_step_neg, n_step_neg;
    logic [15:0]        r_ramp, n_ramp;
    logic signed [15:0] r_fx, n_fx, r_fy, n_fy, r_fz, n_fz;

    // shared arithmetic
    logic [15:0]        r_phase, n_phase;
    logic [30:0]        r_dvd, n_dvd;
    logic [15:0]        r_rem, n_rem;
    logic [15:0]        r_per, n_per;
    logic [4:0]         r_cnt, n_cnt;

    logic               r_m_valid, n_m_valid;
    logic [103:0]       r_m_data, n_m_data;

    // combinational helpers
    logic               in_acc;
    logic [15:0]        per_eff, phase_use;
    logic [16:0]        phase_inc;
    logic [8:0]         tgt, x_deg, trig_deg;
    logic signed [10:0] del;
    t_trig              trig;
    logic [14:0]        mul_a;
    logic [15:0]        mul_b;
    logic [30:0]        prod;
    logic [31:0]        rounded;
    logic [15:0]        mag;
    logic signed [15:0] axis_val;
    logic [16:0]        div_t;
    logic               div_ge;
    logic [15:0]        pz, nz, px, nx, py, ny;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_xy   <= 15'd3277;
            r_amp_z    <= 15'd3277;
            r_period   <= 16'd10;
            r_gradient <= 1'b0;
            r_move_dir <= 1'b0;
            r_pause    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AMP_XY:        r_amp_xy   <= i_cfg_data[14:0];
                CFG_AMP_Z:         r_amp_z    <= i_cfg_data[14:0];
                CFG_PERIOD_TICKS:  r_period   <= i_cfg_data;
                CFG_GRADIENT_MODE: r_gradient <= i_cfg_data[0];
                CFG_MOVE_DIR:      r_move_dir <= i_cfg_data[0];
                CFG_PAUSE:         r_pause    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_heading  <= '0;
            r_steps    <= '0;
            r_step_neg <= 1'b0;
            r_ramp     <= '0;
            r_fx       <= '0;
            r_fy       <= '0;
            r_fz       <= '0;
            r_m_valid  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_heading  <= n_heading;
            r_steps    <= n_steps;
            r_step_neg <= n_step_neg;
            r_ramp     <= n_ramp;
            r_fx       <= n_fx;
            r_fy       <= n_fy;
            r_fz       <= n_fz;
            r_m_valid  <= n_m_valid;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_per    <= n_per;
        r_m_data <= n_m_data;
    end

    // shared multiplier with rounding for the trig path
    always_comb begin
        x_deg    = (r_heading >= 9'(3 * QUARTER_TURN)) ? r_heading - 9'(3 * QUARTER_TURN)
                                                     : r_heading + 9'(QUARTER_TURN);
        trig_deg = (r_state == ST_MUL_X) ? x_deg : r_heading;
        trig     = trig_split(trig_deg);
        if (r_state == ST_RAMP_MUL) begin
            mul_a = r_amp_z;
            mul_b = r_phase;
        end else begin
            mul_a = r_amp_xy;
            mul_b = sine_q(trig.idx);
        end
        prod     = 31'(mul_a * mul_b);
        rounded  = {1'b0, prod} + 32'd16384;
        mag      = {1'b0, rounded[29:15]};
        axis_val = trig.neg ? -$signed(mag) : $signed(mag);
    end

    // one restoring divide step
    always_comb begin
        div_t  = {r_rem, r_dvd[30]};
        div_ge = div_t >= {1'b0, r_per};
    end

    // input decode
    always_comb begin
        per_eff   = (r_period == 16'd0) ? 16'd1 : r_period;
        phase_use = (r_ramp < per_eff) ? r_ramp : 16'd0;
        phase_inc = {1'b0, phase_use} + 17'd1;
        tgt       = (s_axis_tdata[8:0] >= 9'(TRIG_ENTRIES))
                    ? s_axis_tdata[8:0] - 9'(TRIG_ENTRIES) : s_axis_tdata[8:0];
        del       = $signed({2'b00, tgt}) - $signed({2'b00, r_heading});
        if (del > 11'sd180) begin
            del = del - 11'(TRIG_ENTRIES);
        end else if (del < -11'sd180) begin
            del = del + 11'(TRIG_ENTRIES);
        end
    end

    // gradient split of the three axes
    always_comb begin
        pz = r_fz; nz = r_fz;
        px = r_fx; nx = r_fx;
        py = r_fy; ny = r_fy;
        if (r_gradient) begin
            if (r_fz[15]) pz = '0; else nz = '0;
            if (r_fx[15]) px = '0; else nx = '0;
            if (r_fy[15]) py = '0; else ny = '0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_heading  = r_heading;
        n_steps    = r_steps;
        n_step_neg = r_step_neg;
        n_ramp     = r_ramp;
        n_fx       = r_fx;
        n_fy       = r_fy;
        n_fz       = r_fz;
        n_phase    = r_phase;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_per      = r_per;
        n_cnt      = r_cnt;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        n_step_neg = del[10];
                        n_steps    = del[10] ? 8'(-del) : del[7:0];
                        n_fz       = '0;
                        n_state    = ST_EMIT;
                    end else if (r_steps != 8'd0) begin
                        if (r_step_neg) begin
                            n_heading = (r_heading == 9'd0) ? 9'(TRIG_ENTRIES - 1)
                                                            : r_heading - 9'd1;
                        end else begin
                            n_heading = (r_heading == 9'(TRIG_ENTRIES - 1)) ? 9'd0
                                                                         : r_heading + 9'd1;
                        end
                        n_steps = r_steps - 8'd1;
                        n_fz    = '0;
                        n_state = ST_MUL_X;
                    end else begin
                        n_ramp  = (phase_inc >= {1'b0, per_eff}) ? 16'd0 : phase_inc[15:0];
                        n_phase = phase_use;
                        n_per   = per_eff;
                        if (!r_pause) begin
                            n_state = ST_RAMP_MUL;
                        end
                    end
                end
            end
            ST_MUL_X: begin
                n_fx    = axis_val;
                n_state = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                n_fy    = axis_val;
                n_state = ST_EMIT;
            end
            ST_RAMP_MUL: begin
                n_dvd   = prod;
                n_rem   = '0;
                n_cnt   = 5'(DIV_STEPS - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = div_ge ? 16'(div_t - {1'b0, r_per}) : div_t[15:0];
                n_dvd = {r_dvd[29:0], div_ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // z holds the quotient only when reached through the divider
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, (r_steps != 8'd0), ny, py, nx, px, nz, pz};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // divider finishing: publish signed z on the last step
        if (r_state == ST_DIV && r_cnt == 5'd0) begin
            n_fz = r_move_dir ? $signed({1'b0, n_dvd[14:0]}) : -$signed({1'b0, n_dvd[14:0]});
        end
    end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import cfvg_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 50;

    typedef struct {
        logic signed [15:0] pz;
        logic signed [15:0] nz;
        logic signed [15:0] px;
        logic signed [15:0] nx;
        logic signed [15:0] py;
        logic signed [15:0] ny;
        logic               rot;
    } t_drive_word;

    // sine over one quarter turn in whole degrees, scaled by 32768
    int quarter_sine [91] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [15:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;   // [8:0] target_angle
    logic                 s_axis_tuser  = 1'b0; // [0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] drive_pz, [31:16] drive_nz, [47:32] drive_px, [63:48] drive_nx,
    // [79:64] drive_py, [95:80] drive_ny, [96] rotating
    logic [103:0]         m_axis_tdata;

    coil_field_vector_generator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor copy of the configuration, reset values
    logic [14:0] amp_xy_cfg   = 15'd3277;
    logic [14:0] amp_z_cfg    = 15'd3277;
    logic [15:0] period_cfg   = 16'd10;
    logic        grad_cfg     = 1'b0;
    logic        dir_cfg      = 1'b0;
    logic        pause_cfg    = 1'b0;

    // predictor copy of the state
    logic [8:0]         heading    = '0;
    logic [7:0]         steps_left = '0;
    logic               step_neg   = 1'b0;
    logic [15:0]        ramp_phase = '0;
    logic signed [15:0] field_x    = '0;
    logic signed [15:0] field_y    = '0;
    logic signed [15:0] field_z    = '0;

    t_drive_word pending_drive [$];

    int  errors        = 0;
    int  items_sent    = 0;
    int  words_checked = 0;
    int  settings_used = 0;
    int  cycle_count   = 0;
    int  burst_left    = 0;
    bit  tx_full_speed = 1'b0;

    logic rx_full_speed = 1'b0;
    int   hold_req      = 0;
    int   hold_ack      = 0;
    int   hold_left     = 0;
    int   rx_run        = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic signed [15:0] amp_sine(input logic [14:0] amp, input int deg);
        int a;
        int d;
        int q;
        int r;
        int idx;
        int mag;
        a   = amp;
        d   = deg % 360;
        q   = d / 90;
        r   = d % 90;
        idx = (q % 2 == 1) ? 90 - r : r;
        mag = (a * quarter_sine[idx] + 16384) >>> 15;
        return 16'((q >= 2) ? -mag : mag);
    endfunction

    // gradient mode routes each axis onto one coil by sign
    function automatic t_drive_word coil_split(input logic signed [15:0] z,
                                               input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic rot);
        t_drive_word w;
        w.pz = z; w.nz = z;
        w.px = x; w.nx = x;
        w.py = y; w.ny = y;
        w.rot = rot;
        if (grad_cfg) begin
            if (z >= 0) w.nz = '0; else w.pz = '0;
            if (x >= 0) w.nx = '0; else w.px = '0;
            if (y >= 0) w.ny = '0; else w.py = '0;
        end
        return w;
    endfunction

    task automatic predict_drive(input logic cmd, input logic [8:0] angle);
        int t;
        int del;
        int h;
        int period;
        int phase;
        int mag;
        if (cmd) begin
            t = angle;
            if (t >= 360) t -= 360;
            h = heading;
            del = t - h;
            if (del > 180) del -= 360;
            if (del < -180) del += 360;
            step_neg   = (del < 0);
            steps_left = 8'((del < 0) ? -del : del);
            field_z    = '0;
            pending_drive.push_back(coil_split(field_z, field_x, field_y, steps_left != 0));
        end else if (steps_left != 0) begin
            // a tick during a turn steps the heading whatever pause is
            h = heading;
            h = step_neg ? (h + 359) % 360 : (h + 1) % 360;
            heading = h[8:0];
            field_x = amp_sine(amp_xy_cfg, (h + 90) % 360);
            field_y = amp_sine(amp_xy_cfg, h);
            field_z = '0;
            steps_left--;
            pending_drive.push_back(coil_split(field_z, field_x, field_y, steps_left != 0));
        end else begin
            period = period_cfg;
            if (period == 0) period = 1;
            phase = ramp_phase;
            if (phase >= period) phase = 0;
            if (!pause_cfg) begin
                mag = int'((longint'(amp_z_cfg) * phase) / period);
                field_z = 16'(dir_cfg ? mag : -mag);
                pending_drive.push_back(coil_split(field_z, field_x, field_y, 1'b0));
            end
            phase++;
            ramp_phase = 16'((phase >= period) ? 0 : phase);
        end
    endtask

    task automatic report(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic signed [15:0] got,
                               input logic signed [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_drive_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_drive.size() == 0) begin
                report($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                want = pending_drive.pop_front();
                check_field("drive_pz", m_axis_tdata[15:0],  want.pz);
                check_field("drive_nz", m_axis_tdata[31:16], want.nz);
                check_field("drive_px", m_axis_tdata[47:32], want.px);
                check_field("drive_nx", m_axis_tdata[63:48], want.nx);
                check_field("drive_py", m_axis_tdata[79:64], want.py);
                check_field("drive_ny", m_axis_tdata[95:80], want.ny);
                check_field("rotating", {15'd0, m_axis_tdata[96]}, {15'd0, want.rot});
            end
            words_checked++;
        end
    end

    // receiver: alternating ready and stall runs, plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_full_speed) begin
            m_axis_tready <= 1'b1;
        end else if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else begin
            m_axis_tready <= ~m_axis_tready;
            rx_run        <= m_axis_tready ? $urandom_range(1, 15) : $urandom_range(1, 25);
        end
    end

    task automatic send_word(input logic cmd, input logic [8:0] angle);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, angle};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_drive(cmd, angle);
        items_sent++;
        if (!tx_full_speed) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(0, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_tick();
        send_word(1'b0, 9'($urandom_range(0, 511)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_tick();
    endtask

    // sender stops and waits out every due word plus the block's own latency
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input int axy, input int az, input int per,
                                  input bit grad, input bit dir, input bit pse);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [15:0]          val [6];
        settle();
        idx[0] = CFG_AMP_XY;        val[0] = 16'(axy);
        idx[1] = CFG_AMP_Z;         val[1] = 16'(az);
        idx[2] = CFG_PERIOD_TICKS;  val[2] = 16'(per);
        idx[3] = CFG_GRADIENT_MODE; val[3] = {15'd0, grad};
        idx[4] = CFG_MOVE_DIR;      val[4] = {15'd0, dir};
        idx[5] = CFG_PAUSE;         val[5] = {15'd0, pse};
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                CFG_AMP_XY:        amp_xy_cfg = val[i][14:0];
                CFG_AMP_Z:         amp_z_cfg  = val[i][14:0];
                CFG_PERIOD_TICKS:  period_cfg = val[i];
                CFG_GRADIENT_MODE: grad_cfg   = val[i][0];
                CFG_MOVE_DIR:      dir_cfg    = val[i][0];
                CFG_PAUSE:         pause_cfg  = val[i][0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic do_reset();
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_reset_values();
        send_ticks(4);
        send_word(1'b1, 9'd45);
        send_ticks(3);
    endtask

    task automatic test_headings();
        apply_settings(32767, 32767, 4, 1'b0, 1'b1, 1'b0);
        send_ticks(2);
        send_word(1'b1, 9'd90);
        send_ticks(3);
        // out-of-range target while still turning: restarts from heading reached
        send_word(1'b1, 9'd511);
        send_ticks(2);
        send_word(1'b1, 9'd359);
        while (steps_left != 0) send_tick();
        send_tick();
        send_word(1'b1, heading);
        send_word(1'b1, 9'd360);
        apply_settings(20000, 9000, 3, 1'b1, 1'b0, 1'b0);
        send_word(1'b1, 9'd225);
        send_ticks(4);
        send_word(1'b1, 9'd0);
        while (steps_left != 0) send_tick();
        send_ticks(3);
    endtask

    task automatic test_ramp_edges();
        apply_settings(0, 32767, 0, 1'b0, 1'b1, 1'b0);
        send_ticks(3);
        apply_settings(32767, 32767, 1, 1'b1, 1'b0, 1'b0);
        send_ticks(3);
        apply_settings(1234, 32767, 7, 1'b0, 1'b1, 1'b1);
        send_ticks(5);
        // paused, but a turn still answers every tick
        send_word(1'b1, 9'($urandom_range(0, 359)));
        send_ticks(4);
        // leave the phase above a shorter period
        apply_settings(5000, 30000, 60, 1'b1, 1'b1, 1'b0);
        while (steps_left != 0) send_tick();
        send_ticks(40);
        apply_settings(5000, 30000, 9, 1'b1, 1'b0, 1'b0);
        send_ticks(5);
    endtask

    task automatic test_half_turns();
        apply_settings(32767, 1000, 5, 1'b0, 1'b1, 1'b0);
        send_word(1'b1, 9'd0);
        while (steps_left != 0) send_tick();
        send_word(1'b1, 9'd180);
        while (steps_left != 0) send_tick();
        send_word(1'b1, 9'd0);
        while (steps_left != 0) send_tick();
    endtask

    task automatic test_backpressure();
        apply_settings(15000, 25000, 7, 1'b0, 1'b1, 1'b0);
        tx_full_speed = 1'b1;
        hold_req <= hold_req + 1;
        send_word(1'b1, 9'd300);
        send_ticks(30);
        tx_full_speed = 1'b0;
        settle();
    endtask

    task automatic test_random();
        int axy;
        int per;
        bit pse;
        for (int p = 0; p < RAND_PHASES; p++) begin
            axy = (p == 0) ? 32767 : (p == 1) ? 0 : $urandom_range(0, 32767);
            per = (p == 2) ? 1 : (p == 3) ? 65535 : $urandom_range(1, 40);
            pse = (p == 4) ? 1'b1 : ($urandom_range(0, 3) == 0);
            apply_settings(axy, (p == 3) ? 32767 : $urandom_range(0, 32767), per,
                           p[0], p[1], pse);
            if (p == RAND_PHASES - 1) begin
                tx_full_speed = 1'b1;
                rx_full_speed <= 1'b1;
            end
            // mostly ticks, so turns run far; commands land mid-turn now and then
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 6)
                    send_word(1'b1, 9'($urandom_range(0, 511)));
                else
                    send_tick();
            end
        end
        tx_full_speed = 1'b0;
        rx_full_speed <= 1'b0;
    endtask

    initial begin
        do_reset();
        test_reset_values();
        test_headings();
        test_ramp_edges();
        test_half_turns();
        test_backpressure();
        test_random();
        settle();
        $display("tb: %0d words sent, %0d results checked over %0d register settings",
                 items_sent, words_checked, settings_used);
        $display("tb: covered turns both ways, half turns, ramps, pause, gradient split");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== coil_field_vector_generator_core.f =====
hdl/cfvg_pkg.sv
hdl/coil_field_vector_generator_core.sv
bench/testbench.sv
